// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl files
// no dependencies; included by the top-level module, which checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define TAV_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tav assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define TAV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tav assertion failed");

`endif

// ----- rtl/tav_pkg.sv -----
`timescale 1ns / 1ps
// shared widths, types and register codes for the tarch variance core
// no dependencies
package tav_pkg;

   localparam int RES_W    = 16;             // residual, signed q4.12
   localparam int COEF_W   = 16;             // coefficient, q0.16
   localparam int CONST_W  = 32;             // constant term, q8.24
   localparam int VAR_W    = 34;             // variance, q10.24
   localparam int MAG_W    = RES_W;          // magnitude of a residual
   localparam int SQ_W     = 2 * RES_W - 1;  // square fits below 2^31
   localparam int PROD_W   = SQ_W + COEF_W;
   localparam int TERM_W   = 30;             // term after dropping q0.16 fraction
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = CONST_W;
   localparam int MAX_LAGS = 3;
   localparam int LAGS_DEFAULT = 3;

   typedef logic signed [RES_W-1:0] residual_type;
   typedef logic [COEF_W-1:0]       coef_type;
   typedef logic [CONST_W-1:0]      const_type;
   typedef logic [VAR_W-1:0]        variance_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONST_TERM = 3'd0,
      CSR_POS_LAG1   = 3'd1,
      CSR_POS_LAG2   = 3'd2,
      CSR_POS_LAG3   = 3'd3,
      CSR_NEG_LAG1   = 3'd4,
      CSR_NEG_LAG2   = 3'd5,
      CSR_NEG_LAG3   = 3'd6
   } csr_idx_type;

   localparam csr_idx_type POS_IDX [MAX_LAGS] = '{CSR_POS_LAG1, CSR_POS_LAG2, CSR_POS_LAG3};
   localparam csr_idx_type NEG_IDX [MAX_LAGS] = '{CSR_NEG_LAG1, CSR_NEG_LAG2, CSR_NEG_LAG3};

   // control handed from the sequencer to every cell of the chain
   typedef struct packed {
      logic capture;  // a transfer on the request channel this cycle
      logic clear;    // series start: history reads as zero
   } cell_ctl_type;

endpackage

// ----- rtl/tav_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces for the tarch variance core
// depends on tav_pkg
interface tav_req_if
   import tav_pkg::*;
   ();
   logic         valid;
   logic         ready;
   residual_type residual;
   logic         series_start;
   modport source (output valid, output residual, output series_start, input ready);
   modport sink   (input valid, input residual, input series_start, output ready);
endinterface

interface tav_rsp_if
   import tav_pkg::*;
   ();
   logic         valid;
   logic         ready;
   variance_type variance;
   modport source (output valid, output variance, input ready);
   modport sink   (input valid, input variance, output ready);
endinterface

interface tav_csr_if
   import tav_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/tav_cell.sv -----
`timescale 1ns / 1ps
// one lag cell: holds a history residual, forms its weighted square and
// adds it to the partial sum passed down the chain; depends on tav_pkg
module tav_cell
   import tav_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  residual_type hist_in,
   output residual_type hist_out,
   input  coef_type     pos_coef,
   input  coef_type     neg_coef,
   input  variance_type psum_in,
   output variance_type psum_out
);

   residual_type       hist_ff;
   residual_type       use_val;
   logic [MAG_W-1:0]   mag;
   logic [2*MAG_W-1:0] mag_sq;
   logic [SQ_W-1:0]    sq_ff;
   logic               pos_ff;
   coef_type           coef_sel;
   logic [PROD_W-1:0]  prod;
   logic [TERM_W-1:0]  term_ff;
   variance_type       psum_ff;

   // cleared history reads as zero for this item
   assign use_val  = ctl.clear ? '0 : hist_ff;
   assign hist_out = use_val;

   assign mag    = use_val[RES_W-1] ? MAG_W'(-use_val) : MAG_W'(use_val);
   assign mag_sq = {{MAG_W{1'b0}}, mag} * {{MAG_W{1'b0}}, mag};

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else if (ctl.capture) begin
         hist_ff <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         sq_ff  <= mag_sq[SQ_W-1:0];
         pos_ff <= (use_val > 0);
      end
   end

   // zero residual takes the negative set
   assign coef_sel = pos_ff ? pos_coef : neg_coef;
   assign prod     = PROD_W'(sq_ff) * PROD_W'(coef_sel);

   always_ff @(posedge clock) begin
      term_ff <= prod[COEF_W +: TERM_W];
      psum_ff <= psum_in + VAR_W'(term_ff);
   end

   assign psum_out = psum_ff;

endmodule

// ----- rtl/tav_csr.sv -----
`timescale 1ns / 1ps
// configuration registers: constant term and the two coefficient sets
// depends on tav_pkg and tav_if
module tav_csr
   import tav_pkg::*;
#(
   parameter int LAGS = LAGS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tav_csr_if.sink    csr_ch,
   output const_type  const_term,
   output coef_type   pos_coef [LAGS],
   output coef_type   neg_coef [LAGS]
);

   const_type const_ff, const_in;
   coef_type  pos_ff [LAGS];
   coef_type  pos_in [LAGS];
   coef_type  neg_ff [LAGS];
   coef_type  neg_in [LAGS];
   logic      wr;

   assign csr_ch.ready = 1'b1;
   assign wr = csr_ch.valid;

   always_comb begin
      const_in = const_ff;
      pos_in   = pos_ff;
      neg_in   = neg_ff;
      if (wr) begin
         if (csr_ch.index == CSR_CONST_TERM) begin
            const_in = csr_ch.data[CONST_W-1:0];
         end
         // lags past LAGS have no storage; their writes drop
         for (int k = 0; k < LAGS; k++) begin
            if (csr_ch.index == POS_IDX[k]) begin
               pos_in[k] = csr_ch.data[COEF_W-1:0];
            end
            if (csr_ch.index == NEG_IDX[k]) begin
               neg_in[k] = csr_ch.data[COEF_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         const_ff <= '0;
         for (int k = 0; k < LAGS; k++) begin
            pos_ff[k] <= '0;
            neg_ff[k] <= '0;
         end
      end else begin
         const_ff <= const_in;
         pos_ff   <= pos_in;
         neg_ff   <= neg_in;
      end
   end

   assign const_term = const_ff;
   assign pos_coef   = pos_ff;
   assign neg_coef   = neg_ff;

endmodule

// ----- rtl/threshold_arch_variance_core.sv -----
`timescale 1ns / 1ps
// threshold-arch conditional variance core, top level
// depends on tav_pkg, tav_if, tav_cell, tav_csr and assert_macros.svh
//
// usage
//  - req_ch carries one residual (signed q4.12) and a series_start flag per
//    transfer; series_start zeroes the residual history before that item
//  - rsp_ch returns exactly one variance (unsigned q10.24) per request, in order
//  - csr_ch writes the constant term (index 0) and the positive and negative
//    lag coefficients (indices 1-3 and 4-6); other indices are dropped;
//    write only while the core is idle; csr_ch.ready is always high
//  - a request is taken only once the sum of the item before it, walking one
//    cell per cycle down the chain of LAGS cells, has been loaded into the
//    output register
//  - a request may be taken while an earlier result still waits on rsp_ch;
//    a finished sum then holds in the last cell until the output register frees
//  - a stalled rsp_ch holds its result; no result is dropped
//  - reset (synchronous, active high) zeroes history, configuration registers and control
//
module threshold_arch_variance_core
   import tav_pkg::*;
#(
   parameter int LAGS = LAGS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   tav_req_if.sink  req_ch,
   tav_rsp_if.source rsp_ch,
   tav_csr_if.sink  csr_ch
);

`include "assert_macros.svh"

   localparam int CNT_DONE = LAGS + 1;
   localparam int CNT_W    = $clog2(LAGS + 2);

   const_type    const_term;
   coef_type     pos_coef [LAGS];
   coef_type     neg_coef [LAGS];
   cell_ctl_type ctl;
   residual_type hist_link [LAGS];
   variance_type psum [LAGS];

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   variance_type     rsp_variance_ff;
   logic             accept;
   logic             done;
   logic             load;

   // configuration registers
   tav_csr #(.LAGS(LAGS)) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_ch     (csr_ch),
      .const_term (const_term),
      .pos_coef   (pos_coef),
      .neg_coef   (neg_coef)
   );

   // sequencer: one item in flight, counted from the capture edge
   assign req_ch.ready = !busy_ff;
   assign accept       = req_ch.valid && !busy_ff;
   assign done         = busy_ff && (cnt_ff == CNT_W'(CNT_DONE));
   assign load         = done && (!rsp_valid_ff || rsp_ch.ready);

   assign ctl.capture = accept;
   assign ctl.clear   = req_ch.series_start;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (load) begin
         busy_in = 1'b0;
      end else if (busy_ff && !done) begin
         cnt_in = cnt_ff + 1'b1;
      end
      rsp_valid_in = load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // chain of lag cells: history shifts one cell per transfer, the partial
   // sum moves one cell per cycle starting from the constant term
   for (genvar k = 0; k < LAGS; k++) begin : g_cell
      residual_type hist_src;
      variance_type psum_src;
      if (k == 0) begin : g_head
         assign hist_src = req_ch.residual;
         assign psum_src = VAR_W'(const_term);
      end else begin : g_body
         assign hist_src = hist_link[k-1];
         assign psum_src = psum[k-1];
      end
      tav_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .hist_in  (hist_src),
         .hist_out (hist_link[k]),
         .pos_coef (pos_coef[k]),
         .neg_coef (neg_coef[k]),
         .psum_in  (psum_src),
         .psum_out (psum[k])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_variance_ff <= psum[LAGS-1];
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.variance = rsp_variance_ff;

   // a transfer starts the count from zero
   `TAV_ASSERT_NEXT(a_accept_starts, clock, reset, accept, busy_ff && (cnt_ff == '0))
   // an item never leaves before its sum has walked the whole chain
   `TAV_ASSERT_NEXT(a_busy_holds, clock, reset, busy_ff && !done, busy_ff)
   // a finished sum blocked by a stalled output stays in flight
   `TAV_ASSERT_NEXT(a_done_waits, clock, reset,
                    done && rsp_valid_ff && !rsp_ch.ready, busy_ff && done)

endmodule

// ----- dv/threshold_arch_variance_core_test.sv -----
`timescale 1ns / 1ps
// self-checking test of threshold_arch_variance_core: a shadow model of the
// tarch variance sum predicts each result, checked in order on the rsp channel
// depends on tav_pkg, tav_if and the core rtl
module threshold_arch_variance_core_test;
   import tav_pkg::*;

   localparam int DUT_LAGS       = LAGS_DEFAULT;
   localparam int SETTLE_CYCLES  = 4 * (DUT_LAGS + 3);
   localparam int WATCHDOG_LIMIT = 4000;   // cycles without any transfer
   localparam int HOLDOFF_CYCLES = 400;    // long receiver stall for the fill-up test
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 100;

   // index 7 decodes to no register
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 3'd7;

   localparam residual_type RES_MIN = 16'sh8000;
   localparam residual_type RES_MAX = 16'sh7fff;
   localparam residual_type RES_ONE = 16'sh1000;   // 1.0 in q4.12

   localparam coef_type COEF_MAX = 16'hffff;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PATTERN
   } ready_mode_type;

   logic clock;
   logic reset;

   tav_req_if req_if ();
   tav_rsp_if rsp_if ();
   tav_csr_if csr_if ();

   threshold_arch_variance_core #(
      .LAGS (DUT_LAGS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // shadow copy of the core's registers and residual history
   const_type    shadow_const;
   coef_type     shadow_pos [MAX_LAGS];
   coef_type     shadow_neg [MAX_LAGS];
   residual_type shadow_history [MAX_LAGS];

   // variances still owed by the core, oldest first
   variance_type pending_variance [$];
   variance_type oldest_variance;

   int failures;
   int idle_cycles;

   // sender pacing
   int unsigned burst_left;

   // receiver pacing
   int unsigned    holdoff_left;
   int unsigned    segment_left;
   ready_mode_type ready_mode;
   logic [7:0]     ready_pattern;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // tarch variance of one date, then shift the residual into history
   // ------------------------------------------------------------------
   function automatic variance_type predict_variance(input residual_type residual,
                                                     input logic series_start);
      longint unsigned sum;
      longint unsigned mag;
      coef_type        coef;
      int              value;
      int              i;
      if (series_start) begin
         // series start: earlier dates count as zero
         for (i = 0; i < MAX_LAGS; i++) shadow_history[i] = '0;
      end
      sum = shadow_const;
      for (i = 0; i < MAX_LAGS && i < DUT_LAGS; i++) begin
         value = shadow_history[i];
         mag   = (value < 0) ? -value : value;
         // a zero residual picks the negative set, its term is zero anyway
         coef  = (shadow_history[i] > 0) ? shadow_pos[i] : shadow_neg[i];
         // square is q8.24, times q0.16, fraction truncated back to q8.24
         sum   = sum + ((mag * mag * coef) >> 16);
      end
      for (i = MAX_LAGS - 1; i > 0; i--) shadow_history[i] = shadow_history[i-1];
      shadow_history[0] = residual;
      return sum[VAR_W-1:0];
   endfunction

   // ------------------------------------------------------------------
   // monitor: every channel sampled at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            idle_cycles = 0;
         else
            idle_cycles = idle_cycles + 1;

         // register write transfer: values above the width are dropped
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_CONST_TERM: shadow_const = csr_if.data;
               CSR_POS_LAG1:   shadow_pos[0] = csr_if.data[COEF_W-1:0];
               CSR_POS_LAG2:   shadow_pos[1] = csr_if.data[COEF_W-1:0];
               CSR_POS_LAG3:   shadow_pos[2] = csr_if.data[COEF_W-1:0];
               CSR_NEG_LAG1:   shadow_neg[0] = csr_if.data[COEF_W-1:0];
               CSR_NEG_LAG2:   shadow_neg[1] = csr_if.data[COEF_W-1:0];
               CSR_NEG_LAG3:   shadow_neg[2] = csr_if.data[COEF_W-1:0];
               default: ;   // unused index, write ignored
            endcase
         end

         // request transfer: one variance owed per residual
         if (req_if.valid && req_if.ready)
            pending_variance.push_back(predict_variance(req_if.residual,
                                                        req_if.series_start));

         // response transfer: compare with the oldest owed variance
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_variance.size() == 0) begin
               failures++;
               $display("%0t: variance transfer with nothing pending, expected none actual %h",
                        $time, rsp_if.variance);
            end else begin
               oldest_variance = pending_variance.pop_front();
               if (rsp_if.variance !== oldest_variance) begin
                  failures++;
                  $display("%0t: variance mismatch, expected %h actual %h",
                           $time, oldest_variance, rsp_if.variance);
               end
            end
         end
      end
   end

   // watchdog: the run is stuck when nothing moves for too long
   initial begin
      idle_cycles = 0;
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // receiver: stretches of always-ready, random stalls and a rotating
   // stall pattern; a requested hold-off is counted down here
   // ------------------------------------------------------------------
   initial begin
      rsp_if.ready  = 1'b0;
      holdoff_left  = 0;
      segment_left  = 0;
      ready_mode    = READY_ALWAYS;
      ready_pattern = 8'hff;
      forever begin
         @(negedge clock);
         if (holdoff_left > 0) begin
            rsp_if.ready <= 1'b0;
            holdoff_left = holdoff_left - 1;
         end else begin
            if (segment_left == 0) begin
               segment_left  = $urandom_range(8, 64);
               ready_mode    = ready_mode_type'($urandom_range(0, 2));
               ready_pattern = 8'($urandom);
            end
            segment_left = segment_left - 1;
            case (ready_mode)
               READY_ALWAYS: rsp_if.ready <= 1'b1;
               READY_RANDOM: rsp_if.ready <= ($urandom_range(0, 3) != 0);
               default: begin
                  rsp_if.ready <= ready_pattern[0];
                  ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
               end
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------

   // offer one residual, wait for its transfer; bursts with random gaps
   task automatic send_residual(input residual_type residual, input logic series_start);
      int unsigned gap;
      if (burst_left == 0) begin
         // now and then a long run with no idle cycles at all
         burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      burst_left = burst_left - 1;
      @(negedge clock);
      req_if.valid        <= 1'b1;
      req_if.residual     <= residual;
      req_if.series_start <= series_start;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // stop offering and let every owed variance drain
   task automatic wait_idle;
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_variance.size() != 0) @(posedge clock);
      repeat (DUT_LAGS + 3) @(posedge clock);
   endtask

   // all seven registers; coefficient writes carry random upper bits
   // pos[0] / neg[0] is lag one
   task automatic load_setting(input const_type const_term,
                               input logic [MAX_LAGS-1:0][COEF_W-1:0] pos,
                               input logic [MAX_LAGS-1:0][COEF_W-1:0] neg);
      int i;
      write_csr(CSR_CONST_TERM, const_term);
      for (i = 0; i < MAX_LAGS; i++) begin
         write_csr(POS_IDX[i], {16'($urandom), pos[i]});
         write_csr(NEG_IDX[i], {16'($urandom), neg[i]});
      end
   endtask

   // mostly full-range values, some extremes and some near zero
   function automatic residual_type random_residual();
      int pick;
      int near;
      pick = $urandom_range(0, 9);
      near = $urandom_range(0, 64);
      case (pick)
         0: begin
            case ($urandom_range(0, 4))
               0:       return RES_MIN;
               1:       return RES_MAX;
               2:       return '0;
               3:       return -16'sd1;
               default: return 16'sd1;
            endcase
         end
         1:       return residual_type'(near - 32);
         default: return residual_type'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // registers at reset are zero, so every variance is zero
   task automatic test_reset_state;
      send_residual(RES_MAX, 1'b1);
      send_residual(RES_MIN, 1'b0);
      send_residual(16'sd1, 1'b0);
      send_residual('0, 1'b0);
   endtask

   // largest constant and coefficients, largest squares on all lags
   task automatic test_extremes;
      wait_idle;
      load_setting('1, {3{COEF_MAX}}, {3{COEF_MAX}});
      send_residual(RES_MIN, 1'b1);
      send_residual(RES_MIN, 1'b0);
      send_residual(RES_MIN, 1'b0);
      send_residual(RES_MIN, 1'b0);   // three full negative lags
      send_residual(RES_MAX, 1'b0);
      send_residual(RES_MAX, 1'b0);
      send_residual(RES_MAX, 1'b0);
      send_residual('0, 1'b0);        // three full positive lags
      send_residual(16'sd5, 1'b1);    // series start mid-stream: constant only
      send_residual(-16'sd1, 1'b0);   // one short lag
   endtask

   // distinct positive and negative sets show which one each lag picks
   task automatic test_sign_select;
      wait_idle;
      load_setting(32'h0100_0000, {16'h0001, 16'h8000, COEF_MAX},
                   {COEF_MAX, 16'h4000, 16'h0001});
      send_residual(RES_ONE, 1'b1);
      send_residual(-RES_ONE, 1'b0);
      send_residual('0, 1'b0);        // zero residual takes the negative set
      send_residual(RES_ONE, 1'b0);
      send_residual(-16'sd1, 1'b0);
      send_residual(16'sd1, 1'b0);
      send_residual(16'sd2, 1'b0);
   endtask

   // write to the unused index must leave every register as it was
   task automatic test_register_decode;
      wait_idle;
      load_setting($urandom, {16'($urandom), 16'($urandom), 16'($urandom)},
                   {16'($urandom), 16'($urandom), 16'($urandom)});
      write_csr(CSR_UNUSED_IDX, $urandom);
      write_csr(CSR_UNUSED_IDX, '1);
      send_residual(RES_MIN, 1'b1);
      send_residual(RES_MAX, 1'b0);
      send_residual(random_residual(), 1'b0);
      send_residual(random_residual(), 1'b0);
   endtask

   // random series under several settings, extremes among them
   task automatic test_random_series;
      int   phase;
      int   n;
      int   series_left;
      logic series_start;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle;
         case (phase)
            0:       load_setting('1, {3{COEF_MAX}}, {3{COEF_MAX}});
            1:       load_setting('1, '0, '0);
            2:       load_setting('0, {3{COEF_MAX}}, '0);
            3:       load_setting('0, '0, {3{COEF_MAX}});
            default: load_setting($urandom, {16'($urandom), 16'($urandom), 16'($urandom)},
                                  {16'($urandom), 16'($urandom), 16'($urandom)});
         endcase
         series_left = 0;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            series_start = 1'b0;
            if (series_left == 0) begin
               series_left  = $urandom_range(1, 30);
               series_start = 1'b1;
            end else if ($urandom_range(0, 31) == 0) begin
               // a series cut short by a fresh start
               series_start = 1'b1;
            end
            series_left = series_left - 1;
            send_residual(random_residual(), series_start);
         end
      end
   endtask

   // receiver holds off while residuals keep coming, so the core backs up
   task automatic test_output_backpressure;
      int n;
      wait_idle;
      load_setting($urandom, {16'($urandom), 16'($urandom), 16'($urandom)},
                   {16'($urandom), 16'($urandom), 16'($urandom)});
      holdoff_left = HOLDOFF_CYCLES;
      burst_left   = 40;
      for (n = 0; n < 30; n++) send_residual(random_residual(), n == 0);
      wait (holdoff_left == 0);
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      int i;
      failures            = 0;
      burst_left          = 0;
      shadow_const        = '0;
      for (i = 0; i < MAX_LAGS; i++) begin
         shadow_pos[i]     = '0;
         shadow_neg[i]     = '0;
         shadow_history[i] = '0;
      end
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.residual     = '0;
      req_if.series_start = 1'b0;
      csr_if.valid        = 1'b0;
      csr_if.index        = '0;
      csr_if.data         = '0;

      // synchronous reset, released at a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state;
      test_extremes;
      test_sign_select;
      test_register_decode;
      test_random_series;
      test_output_backpressure;

      // drain, then watch a little longer for stray transfers
      wait_idle;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_variance.size() != 0) begin
         failures++;
         $display("%0t: variance still pending at end, expected %h actual none",
                  $time, pending_variance[0]);
      end

      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tav_pkg.sv
rtl/tav_if.sv
rtl/tav_cell.sv
rtl/tav_csr.sv
rtl/threshold_arch_variance_core.sv
dv/threshold_arch_variance_core_test.sv
